// ===== src/sba_pkg.sv =====
// ---------------------------------------------------------------------------
// sba_pkg
// Shared field widths, status codes, action codes and sequencer states of the
// slab bitmap allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package sba_pkg;

    localparam int ACTION_W = 1;
    localparam int SIZE_W   = 12;
    localparam int CLASS_W  = 4;
    localparam int SLOT_W   = 12;
    localparam int STATUS_W = 3;
    localparam int PAGE_W   = 3;
    localparam int OFFSET_W = 12;
    localparam int USED_W   = 13;

    localparam int WORD_BITS = 32;
    localparam int BIT_IDX_W = 5;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_SIZE   = 3'd1,
        STAT_PAGE_LIMIT = 3'd2,
        STAT_NO_GRANT   = 3'd3,
        STAT_BAD_FREE   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CAPCHK,
        S_FREE_CHK,
        S_SCAN_CHK,
        S_DIVIDE,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== src/sba_req_if.sv =====
// ---------------------------------------------------------------------------
// sba_req_if / sba_rsp_if
// Valid/ready channels for allocator request items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface sba_req_if import sba_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SIZE_W-1:0]   req_size;
    logic [CLASS_W-1:0]  free_class;
    logic [SLOT_W-1:0]   free_slot;
    logic                page_grant;

    modport source (output valid, action, req_size, free_class, free_slot, page_grant,
                    input ready);
    modport sink   (input valid, action, req_size, free_class, free_slot, page_grant,
                    output ready);
endinterface

interface sba_rsp_if import sba_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CLASS_W-1:0]  size_class;
    logic [SLOT_W-1:0]   slot_index;
    logic [PAGE_W-1:0]   page_num;
    logic [OFFSET_W-1:0] byte_offset;
    logic                page_taken;
    logic [USED_W-1:0]   used_count;

    modport source (output valid, status, size_class, slot_index, page_num, byte_offset,
                    page_taken, used_count, input ready);
    modport sink   (input valid, status, size_class, slot_index, page_num, byte_offset,
                    page_taken, used_count, output ready);
endinterface

`default_nettype wire

// ===== src/sba_bitmap_ram.sv =====
// ---------------------------------------------------------------------------
// sba_bitmap_ram
// Occupancy bitmap store: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module sba_bitmap_ram import sba_pkg::*; #(
    parameter int DEPTH = 1152,
    parameter int AW    = 11
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WORD_BITS-1:0] wdata,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/sba_page_div.sv =====
// ---------------------------------------------------------------------------
// sba_page_div
// Repeated-subtract divider: splits a slot into page index and slot in page.
// ---------------------------------------------------------------------------
`default_nettype none

module sba_page_div #(
    parameter int DW = 12,
    parameter int VW = 10,
    parameter int QW = 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic      [QW-1:0] quotient,
    output logic      [DW-1:0] remainder
);

    localparam int MW = (DW > VW) ? DW : VW;

    logic          busy_reg;
    logic          done_reg;
    logic [DW-1:0] rem_reg;
    logic [VW-1:0] div_reg;
    logic [QW-1:0] q_reg;
    logic          ge;

    assign ge        = MW'(rem_reg) >= MW'(div_reg);
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && !ge)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            div_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg && ge)
        begin
            rem_reg <= DW'(MW'(rem_reg) - MW'(div_reg));
            q_reg   <= q_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== src/slab_bitmap_allocator_unit.sv =====
// Path, acceptance to result valid: a rejected item ends at decode or a check; an allocate
// takes decode, a capacity check, a first-fit scan over up to 128 bitmap words and a page
// split; a good free takes the checks and the page split. A stalled result adds its wait.
// Flow: one item at a time; no new item is taken until the last result is loaded. The scan
// reads the bitmap memory's single read port. A result waits in an output register.
// Reset: rst_n clears control state, then a clearing pass zeroes all 1152 bitmap words.
`default_nettype none

module slab_bitmap_allocator_unit import sba_pkg::*; #(
    parameter int NUM_CLASSES      = 9,
    parameter int MAX_PAGES        = 8,
    parameter int PAGE_BYTES       = 4096,
    parameter int MIN_OBJECT_BYTES = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sba_req_if.sink    req,
    sba_rsp_if.source  rsp
);

    localparam int SLOTS_MAX = MAX_PAGES * (PAGE_BYTES / MIN_OBJECT_BYTES);
    localparam int WPC       = (SLOTS_MAX + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH     = NUM_CLASSES * WPC;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PW        = $clog2(MAX_PAGES + 1);
    localparam int PPG_MAX   = PAGE_BYTES / MIN_OBJECT_BYTES;
    localparam int PPGW      = $clog2(PPG_MAX + 1);
    localparam int CAPW      = $clog2(SLOTS_MAX + 1);
    localparam int SW        = $clog2(SLOTS_MAX);
    localparam int WW        = (WPC > 1) ? $clog2(WPC) : 1;
    localparam int QW        = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int XW0       = (CAPW > WW + BIT_IDX_W) ? CAPW : WW + BIT_IDX_W;
    localparam int XW        = ((XW0 > SLOT_W) ? XW0 : SLOT_W) + 1;
    localparam int MAX_OBJ   = MIN_OBJECT_BYTES << (NUM_CLASSES - 1);

    state_t state_reg, state_next;

    logic [AW-1:0]       clr_reg;
    logic                act_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [CLASS_W-1:0]  fcls_reg;
    logic [SLOT_W-1:0]   fslot_reg;
    logic                grant_reg;
    logic [CW-1:0]       cls_reg;
    logic [CAPW-1:0]     cap_reg;
    logic [WW-1:0]       word_reg;
    logic                taken_reg;
    logic [PW-1:0]       pages_reg [NUM_CLASSES];
    logic [CAPW-1:0]     used_reg  [NUM_CLASSES];

    logic [STATUS_W-1:0] res_status_reg;
    logic [CLASS_W-1:0]  res_cls_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [PAGE_W-1:0]   res_page_reg;
    logic [OFFSET_W-1:0] res_off_reg;
    logic                res_taken_reg;
    logic [USED_W-1:0]   res_used_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CLASS_W-1:0]  out_cls_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [PAGE_W-1:0]   out_page_reg;
    logic [OFFSET_W-1:0] out_off_reg;
    logic                out_taken_reg;
    logic [USED_W-1:0]   out_used_reg;

    logic [PPGW-1:0]      ppg_tab [NUM_CLASSES];
    logic [CW-1:0]        size_cls;
    logic                 size_bad;
    logic                 fcls_bad;
    logic [PW-1:0]        pages_cur;
    logic [CAPW-1:0]      used_cur;
    logic [PPGW-1:0]      ppg_cur;
    logic [CAPW-1:0]      cap_cur;
    logic                 full;
    logic                 at_limit;
    logic                 slot_oob;
    logic                 zfound;
    logic [BIT_IDX_W-1:0] zpos;
    logic [XW-1:0]        base;
    logic [XW-1:0]        cand;
    logic                 scan_hit;
    logic                 scan_fail;
    logic                 fbit;
    logic [AW-1:0]        class_base;
    logic                 load_out;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 div_start;
    logic [SW-1:0]        div_dividend;
    logic                 div_done;
    logic [QW-1:0]        div_q;
    logic [SW-1:0]        div_rem;

    for (genvar g = 0; g < NUM_CLASSES; g++)
    begin : g_ppg
        localparam int RAW = PAGE_BYTES / (MIN_OBJECT_BYTES << g);
        assign ppg_tab[g] = PPGW'((RAW == 0) ? 1 : RAW);
    end

    sba_bitmap_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sba_page_div #(.DW(SW), .VW(PPGW), .QW(QW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (ppg_cur),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    // decisions shared by the sequencer and the datapath
    always_comb
    begin
        size_cls = CW'(NUM_CLASSES - 1);
        for (int c = NUM_CLASSES - 2; c >= 0; c--)
        begin
            if (32'(size_reg) <= 32'(MIN_OBJECT_BYTES << c))
            begin
                size_cls = CW'(c);
            end
        end
        size_bad = (size_reg == '0) || (32'(size_reg) > 32'(MAX_OBJ));
        fcls_bad = 32'(fcls_reg) >= 32'(NUM_CLASSES);

        pages_cur = pages_reg[cls_reg];
        used_cur  = used_reg[cls_reg];
        ppg_cur   = ppg_tab[cls_reg];
        cap_cur   = CAPW'(pages_cur) * CAPW'(ppg_cur);
        full      = used_cur >= cap_cur;
        at_limit  = 32'(pages_cur) >= 32'(MAX_PAGES);
        slot_oob  = XW'(fslot_reg) >= XW'(cap_cur);

        zfound = 1'b0;
        zpos   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!ram_rdata[b])
            begin
                zfound = 1'b1;
                zpos   = BIT_IDX_W'(b);
            end
        end
        base      = XW'(word_reg) << BIT_IDX_W;
        cand      = base + XW'(zpos);
        scan_hit  = zfound && (cand < XW'(cap_reg));
        scan_fail = !scan_hit && (zfound || (base + XW'(WORD_BITS) >= XW'(cap_reg)));
        fbit      = ram_rdata[fslot_reg[BIT_IDX_W-1:0]];

        class_base = AW'(32'(cls_reg) * WPC);
        load_out   = !out_valid_reg || rsp.ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (act_reg == ACT_ALLOC)
                begin
                    state_next = size_bad ? S_RESP : S_CAPCHK;
                end
                else
                begin
                    state_next = fcls_bad ? S_RESP : S_CAPCHK;
                end
            end
            S_CAPCHK:
            begin
                if (act_reg == ACT_ALLOC)
                begin
                    state_next = (full && (at_limit || !grant_reg)) ? S_RESP : S_SCAN_CHK;
                end
                else
                begin
                    state_next = slot_oob ? S_RESP : S_FREE_CHK;
                end
            end
            S_FREE_CHK:
            begin
                state_next = fbit ? S_DIVIDE : S_RESP;
            end
            S_SCAN_CHK:
            begin
                if (scan_hit)
                begin
                    state_next = S_DIVIDE;
                end
                else if (scan_fail)
                begin
                    state_next = S_RESP;
                end
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req.ready    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = class_base;
        ram_wdata    = '0;
        ram_raddr    = class_base;
        div_start    = 1'b0;
        div_dividend = SW'(fslot_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
            end
            S_CAPCHK:
            begin
                if (act_reg == ACT_FREE)
                begin
                    ram_raddr = class_base + AW'(fslot_reg >> BIT_IDX_W);
                end
            end
            S_FREE_CHK:
            begin
                ram_we    = fbit;
                ram_waddr = class_base + AW'(fslot_reg >> BIT_IDX_W);
                ram_wdata = ram_rdata & ~(WORD_BITS'(1) << fslot_reg[BIT_IDX_W-1:0]);
                div_start = fbit;
            end
            S_SCAN_CHK:
            begin
                // fetch the next word while this one is checked
                ram_raddr    = class_base + AW'(word_reg) + AW'(1);
                ram_we       = scan_hit;
                ram_waddr    = class_base + AW'(word_reg);
                ram_wdata    = ram_rdata | (WORD_BITS'(1) << zpos);
                div_start    = scan_hit;
                div_dividend = SW'(cand);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                pages_reg[c] <= PW'(1);
                used_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_CAPCHK && act_reg == ACT_ALLOC && full && !at_limit
                && grant_reg)
            begin
                pages_reg[cls_reg] <= pages_cur + 1'b1;
            end
            if (state_reg == S_FREE_CHK && fbit)
            begin
                used_reg[cls_reg] <= used_cur - 1'b1;
            end
            if (state_reg == S_SCAN_CHK && scan_hit)
            begin
                used_reg[cls_reg] <= used_cur + 1'b1;
            end
            if (state_reg == S_RESP && load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                act_reg   <= req.action;
                size_reg  <= req.req_size;
                fcls_reg  <= req.free_class;
                fslot_reg <= req.free_slot;
                grant_reg <= req.page_grant;
            end
            S_DECODE:
            begin
                cls_reg       <= (act_reg == ACT_ALLOC) ? size_cls : CW'(fcls_reg);
                taken_reg     <= 1'b0;
                word_reg      <= '0;
                res_page_reg  <= '0;
                res_off_reg   <= '0;
                res_taken_reg <= 1'b0;
                res_used_reg  <= '0;
                if (act_reg == ACT_ALLOC)
                begin
                    res_status_reg <= STAT_BAD_SIZE;
                    res_cls_reg    <= '0;
                    res_slot_reg   <= '0;
                end
                else
                begin
                    res_status_reg <= STAT_BAD_FREE;
                    res_cls_reg    <= fcls_reg;
                    res_slot_reg   <= fslot_reg;
                end
            end
            S_CAPCHK:
            begin
                res_cls_reg  <= CLASS_W'(cls_reg);
                res_used_reg <= USED_W'(used_cur);
                // a granted page widens the scan range by one page
                cap_reg      <= cap_cur + ((act_reg == ACT_ALLOC && full && !at_limit
                                            && grant_reg) ? CAPW'(ppg_cur) : CAPW'(0));
                if (act_reg == ACT_ALLOC)
                begin
                    res_slot_reg <= '0;
                    if (full)
                    begin
                        if (at_limit)
                        begin
                            res_status_reg <= STAT_PAGE_LIMIT;
                        end
                        else if (!grant_reg)
                        begin
                            res_status_reg <= STAT_NO_GRANT;
                        end
                        else
                        begin
                            taken_reg <= 1'b1;
                        end
                    end
                end
                else
                begin
                    res_status_reg <= STAT_BAD_FREE;
                end
            end
            S_FREE_CHK:
            begin
                if (fbit)
                begin
                    res_status_reg <= STAT_OK;
                    res_used_reg   <= USED_W'(used_cur - 1'b1);
                end
            end
            S_SCAN_CHK:
            begin
                word_reg <= word_reg + 1'b1;
                if (scan_hit)
                begin
                    res_status_reg <= STAT_OK;
                    res_slot_reg   <= SLOT_W'(cand);
                    res_taken_reg  <= taken_reg;
                    res_used_reg   <= USED_W'({1'b0, used_cur} + 1'b1);
                end
                else
                begin
                    res_status_reg <= STAT_PAGE_LIMIT;
                end
            end
            S_DIVIDE:
            begin
                res_page_reg <= PAGE_W'(div_q);
                res_off_reg  <= OFFSET_W'((32'(div_rem) * MIN_OBJECT_BYTES) << cls_reg);
            end
            S_RESP:
            begin
                if (load_out)
                begin
                    out_status_reg <= res_status_reg;
                    out_cls_reg    <= res_cls_reg;
                    out_slot_reg   <= res_slot_reg;
                    out_page_reg   <= res_page_reg;
                    out_off_reg    <= res_off_reg;
                    out_taken_reg  <= res_taken_reg;
                    out_used_reg   <= res_used_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.size_class  = out_cls_reg;
    assign rsp.slot_index  = out_slot_reg;
    assign rsp.page_num    = out_page_reg;
    assign rsp.byte_offset = out_off_reg;
    assign rsp.page_taken  = out_taken_reg;
    assign rsp.used_count  = out_used_reg;

endmodule

`default_nettype wire

// ===== src/sba_checker.sv =====
// ---------------------------------------------------------------------------
// sba_checker
// Port-level checks of the slab bitmap allocator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module sba_checker import sba_pkg::*; (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [STATUS_W-1:0] rsp_status,
    input wire logic [CLASS_W-1:0]  rsp_size_class,
    input wire logic [SLOT_W-1:0]   rsp_slot_index,
    input wire logic                rsp_page_taken,
    input wire logic [USED_W-1:0]   rsp_used_count
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
        && $stable(rsp_slot_index) && $stable(rsp_used_count))
        else $error("stalled result changed");

    // one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while busy");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= STAT_BAD_FREE)
        else $error("undefined status code");

    a_bad_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STAT_BAD_SIZE |->
        rsp_size_class == '0 && rsp_slot_index == '0 && rsp_used_count == '0)
        else $error("bad size result carries data");

    a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_page_taken |-> rsp_status == STAT_OK && rsp_used_count != '0)
        else $error("page taken on a failed allocation");

endmodule

bind slab_bitmap_allocator_unit sba_checker u_sba_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_size_class (rsp.size_class),
    .rsp_slot_index (rsp.slot_index),
    .rsp_page_taken (rsp.page_taken),
    .rsp_used_count (rsp.used_count)
);

`default_nettype wire
